@@ rtl/gld_pkg.sv @@
// ----------------------------------------------------------------------------
// gld_pkg: shared types and constants of the LZW decoder
// Code widths, table depth, status codes and the input word format.
// ----------------------------------------------------------------------------
`default_nettype none
package gld_pkg;

	// Code and table geometry
	localparam int CODE_W      = 12;
	localparam int TABLE_DEPTH = 4096;
	localparam int NF_W        = 13;
	localparam int BUF_W       = 20;
	localparam int CNT_W       = 5;
	localparam int ROOT_W      = 9;
	localparam int CW_W        = 4;
	localparam int MIN_WIDTH   = 3;
	localparam int MAX_WIDTH   = 12;
	localparam int MIN_ROOTS   = 4;
	localparam int MAX_ROOTS   = 256;
	localparam int ACCEPT_MAX_BITS = 12;

	// Result status codes
	localparam logic [2:0] STAT_DATA     = 3'd0;
	localparam logic [2:0] STAT_ACCEPTED = 3'd1;
	localparam logic [2:0] STAT_REJECTED = 3'd2;
	localparam logic [2:0] STAT_NEED_IN  = 3'd3;
	localparam logic [2:0] STAT_FINISHED = 3'd4;
	localparam logic [2:0] STAT_ERROR    = 3'd5;

	// Register indexes
	localparam logic REG_FIRST_WIDTH = 1'b0;
	localparam logic REG_ROOT_COUNT  = 1'b1;

	// One input word as queued between front and back
	typedef struct packed {
		logic       pull;
		logic [7:0] coded_byte;
		logic       final_byte;
	} item_t;

endpackage
`default_nettype wire

@@ rtl/gld_front.sv @@
// ----------------------------------------------------------------------------
// gld_front: input side of the LZW decoder
// Takes input words and classifies them (byte supply or pull) into a
// two-entry queue that the decode engine drains.
// ----------------------------------------------------------------------------
`default_nettype none
module gld_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_stall,
	input  wire logic           mode,
	input  wire logic [7:0]     coded_byte,
	input  wire logic           final_byte,
	output logic                q_valid,
	output gld_pkg::item_t      q_item,
	input  wire logic           q_pop
);
	import gld_pkg::*;

	item_t       slot_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;
	logic        push;

	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign q_valid    = (cnt_q != 2'd0);
	assign q_item     = slot_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= '{pull: mode, coded_byte: coded_byte, final_byte: final_byte};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule
`default_nettype wire

@@ rtl/gld_core.sv @@
// ----------------------------------------------------------------------------
// gld_core: decode engine of the LZW decoder
// Bit buffer, code extraction, dictionary memories, chain walk onto the
// output stack, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module gld_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      q_valid,
	input  wire gld_pkg::item_t            q_item,
	output logic                           q_pop,
	input  wire logic [gld_pkg::CW_W-1:0]  eff_width,
	input  wire logic [gld_pkg::ROOT_W-1:0] eff_roots,
	output logic                           result_valid,
	input  wire logic                      result_stall,
	output logic [2:0]                     status,
	output logic [7:0]                     out_byte
);
	import gld_pkg::*;

	// engine states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DEC   = 4'd1;
	localparam logic [3:0] ST_F1    = 4'd2;
	localparam logic [3:0] ST_F2    = 4'd3;
	localparam logic [3:0] ST_WALK  = 4'd4;
	localparam logic [3:0] ST_WALKW = 4'd5;
	localparam logic [3:0] ST_ADD   = 4'd6;
	localparam logic [3:0] ST_POP   = 4'd7;
	localparam logic [3:0] ST_POPW  = 4'd8;
	localparam logic [3:0] ST_RESP  = 4'd9;

	// decoder phases
	localparam logic [2:0] PH_WAIT_CLEAR = 3'd0;
	localparam logic [2:0] PH_FIRST      = 3'd1;
	localparam logic [2:0] PH_RUN        = 3'd2;
	localparam logic [2:0] PH_DONE       = 3'd3;
	localparam logic [2:0] PH_ERROR      = 3'd4;

	localparam int AW = CODE_W;

	// dictionary and stack memories
	logic [CODE_W-1:0] prefix_mem [TABLE_DEPTH];
	logic [7:0]        suffix_mem [TABLE_DEPTH];
	logic [7:0]        first_mem  [TABLE_DEPTH];
	logic [7:0]        stack_mem  [TABLE_DEPTH];

	logic [3:0]        state_q;
	logic [2:0]        phase_q;
	logic [NF_W-1:0]   sd_q;
	logic [NF_W-1:0]   nf_q;
	logic [CW_W-1:0]   cw_q;
	logic [CODE_W-1:0] prev_q;
	logic [BUF_W-1:0]  buf_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ended_q;
	logic [CODE_W-1:0] cur_q;
	logic              kwk_q;
	logic [7:0]        pf_q;
	logic [7:0]        add_b_q;
	logic [CODE_W-1:0] walk_q;
	logic [2:0]        res_stat_q;
	logic [7:0]        res_byte_q;
	logic              rv_q;
	logic [2:0]        stat_q;
	logic [7:0]        byte_q;

	logic [CODE_W-1:0] prefix_rd;
	logic [7:0]        suffix_rd;
	logic [7:0]        first_rd;
	logic [7:0]        stack_rd;

	logic [CW_W-1:0]   dec_w;
	logic [BUF_W-1:0]  dec_mask;
	logic [CODE_W-1:0] dec_code;
	logic [BUF_W-1:0]  dec_buf;
	logic [CODE_W-1:0] first_addr;
	logic              push_en;
	logic [7:0]        push_data;
	logic              stack_we;
	logic              table_we;
	logic [AW-1:0]     stack_raddr;
	logic              out_free;
	logic [NF_W-1:0]   root_ext;
	logic [NF_W-1:0]   code_ext;
	logic              byte_ok;

	assign out_free   = !rv_q || !result_stall;
	assign root_ext   = NF_W'(eff_roots);
	assign code_ext   = NF_W'(dec_code);
	assign byte_ok    = !(phase_q == PH_DONE || phase_q == PH_ERROR || ended_q ||
		cnt_q > CNT_W'(ACCEPT_MAX_BITS));
	assign stack_raddr = AW'(sd_q - NF_W'(1));
	assign stack_we   = push_en && (sd_q < NF_W'(TABLE_DEPTH));
	assign table_we   = (state_q == ST_ADD) && (nf_q < NF_W'(TABLE_DEPTH));
	assign q_pop      = (state_q == ST_IDLE) && q_valid;

	// code extraction from the bit buffer
	always_comb begin
		dec_w    = (phase_q == PH_WAIT_CLEAR) ? eff_width : cw_q;
		dec_mask = (BUF_W'(1) << dec_w) - BUF_W'(1);
		dec_code = CODE_W'(buf_q & dec_mask);
		dec_buf  = buf_q >> dec_w;
	end

	// first-byte table read address and stack push source
	always_comb begin
		first_addr = (state_q == ST_F1) ? cur_q : prev_q;
		push_en    = 1'b0;
		push_data  = 8'd0;
		unique case (state_q)
			ST_DEC: begin
				push_en   = (cnt_q >= CNT_W'(dec_w)) && (phase_q == PH_FIRST) &&
					(code_ext < root_ext);
				push_data = dec_code[7:0];
			end
			ST_F2: begin
				push_en   = kwk_q;
				push_data = pf_q;
			end
			ST_WALK: begin
				push_en   = (NF_W'(walk_q) < root_ext);
				push_data = walk_q[7:0];
			end
			ST_WALKW: begin
				push_en   = 1'b1;
				push_data = suffix_rd;
			end
			default: begin
				push_en   = 1'b0;
				push_data = 8'd0;
			end
		endcase
	end

	// dictionary memories
	always_ff @(posedge clk) begin
		if (table_we) begin
			prefix_mem[nf_q[AW-1:0]] <= prev_q;
			suffix_mem[nf_q[AW-1:0]] <= add_b_q;
			first_mem[nf_q[AW-1:0]]  <= pf_q;
		end
		prefix_rd <= prefix_mem[walk_q];
		suffix_rd <= suffix_mem[walk_q];
		first_rd  <= first_mem[first_addr];
	end

	// output stack memory
	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[sd_q[AW-1:0]] <= push_data;
		end
		stack_rd <= stack_mem[stack_raddr];
	end

	// working registers without reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_DEC: begin
				cur_q <= dec_code;
				kwk_q <= (code_ext == nf_q);
			end
			ST_F1: begin
				pf_q <= (NF_W'(prev_q) < root_ext) ? prev_q[7:0] : first_rd;
			end
			ST_F2: begin
				add_b_q <= kwk_q ? pf_q :
					((NF_W'(cur_q) < root_ext) ? cur_q[7:0] : first_rd);
				walk_q  <= kwk_q ? prev_q : cur_q;
			end
			ST_WALKW: begin
				walk_q <= prefix_rd;
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	// sequencer and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_WAIT_CLEAR;
			sd_q       <= '0;
			nf_q       <= '0;
			cw_q       <= CW_W'(MIN_WIDTH);
			prev_q     <= '0;
			buf_q      <= '0;
			cnt_q      <= '0;
			ended_q    <= 1'b0;
			res_stat_q <= STAT_DATA;
			res_byte_q <= 8'd0;
			rv_q       <= 1'b0;
			stat_q     <= STAT_DATA;
			byte_q     <= 8'd0;
		end else begin
			if (stack_we) sd_q <= sd_q + NF_W'(1);
			if (rv_q && !result_stall) rv_q <= 1'b0;
			res_byte_q <= 8'd0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (!q_item.pull) begin
							if (byte_ok) begin
								buf_q   <= buf_q | (BUF_W'(q_item.coded_byte) << cnt_q);
								cnt_q   <= cnt_q + CNT_W'(8);
								ended_q <= q_item.final_byte;
								res_stat_q <= STAT_ACCEPTED;
							end else begin
								res_stat_q <= STAT_REJECTED;
							end
							state_q <= ST_RESP;
						end else if (sd_q != '0) begin
							state_q <= ST_POP;
						end else if (phase_q == PH_DONE) begin
							res_stat_q <= STAT_FINISHED;
							state_q    <= ST_RESP;
						end else if (phase_q == PH_ERROR) begin
							res_stat_q <= STAT_ERROR;
							state_q    <= ST_RESP;
						end else begin
							state_q <= ST_DEC;
						end
					end
				end
				ST_DEC: begin
					if (cnt_q < CNT_W'(dec_w)) begin
						if (ended_q) begin
							phase_q    <= PH_ERROR;
							res_stat_q <= STAT_ERROR;
						end else begin
							res_stat_q <= STAT_NEED_IN;
						end
						state_q <= ST_RESP;
					end else begin
						buf_q <= dec_buf;
						cnt_q <= cnt_q - CNT_W'(dec_w);
						if (code_ext == root_ext) begin
							// clear code: rebuild roots, stay decoding
							cw_q    <= eff_width;
							nf_q    <= root_ext + NF_W'(2);
							phase_q <= PH_FIRST;
						end else if (phase_q == PH_WAIT_CLEAR) begin
							phase_q    <= PH_ERROR;
							res_stat_q <= STAT_ERROR;
							state_q    <= ST_RESP;
						end else if (code_ext == root_ext + NF_W'(1)) begin
							phase_q    <= PH_DONE;
							res_stat_q <= STAT_FINISHED;
							state_q    <= ST_RESP;
						end else if (phase_q == PH_FIRST) begin
							if (code_ext < root_ext) begin
								prev_q  <= dec_code;
								phase_q <= PH_RUN;
								state_q <= ST_POP;
							end else begin
								phase_q    <= PH_ERROR;
								res_stat_q <= STAT_ERROR;
								state_q    <= ST_RESP;
							end
						end else if (code_ext < nf_q ||
							(code_ext == nf_q && nf_q < NF_W'(TABLE_DEPTH))) begin
							state_q <= ST_F1;
						end else begin
							phase_q    <= PH_ERROR;
							res_stat_q <= STAT_ERROR;
							state_q    <= ST_RESP;
						end
					end
				end
				ST_F1: state_q <= ST_F2;
				ST_F2: state_q <= ST_WALK;
				ST_WALK: begin
					state_q <= (NF_W'(walk_q) < root_ext) ? ST_ADD : ST_WALKW;
				end
				ST_WALKW: state_q <= ST_WALK;
				ST_ADD: begin
					// new entry and width growth
					if (table_we) begin
						if (nf_q >= ((NF_W'(1) << cw_q) - NF_W'(1)) &&
							cw_q < CW_W'(MAX_WIDTH)) begin
							cw_q <= cw_q + CW_W'(1);
						end
						nf_q <= nf_q + NF_W'(1);
					end
					prev_q  <= cur_q;
					state_q <= ST_POP;
				end
				ST_POP: begin
					if (sd_q != '0) begin
						sd_q    <= sd_q - NF_W'(1);
						state_q <= ST_POPW;
					end else begin
						res_stat_q <= STAT_DATA;
						state_q    <= ST_RESP;
					end
				end
				ST_POPW: begin
					res_stat_q <= STAT_DATA;
					res_byte_q <= stack_rd;
					state_q    <= ST_RESP;
				end
				ST_RESP: begin
					res_byte_q <= res_byte_q;
					if (out_free) begin
						rv_q    <= 1'b1;
						stat_q  <= res_stat_q;
						byte_q  <= res_byte_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = rv_q;
	assign status       = stat_q;
	assign out_byte     = byte_q;

endmodule
`default_nettype wire

@@ rtl/gif_lzw_decoder_top.sv @@
// ----------------------------------------------------------------------------
// gif_lzw_decoder_top: GIF-style LZW decoder, variable code width to 12 bits
// Register port, input queue and decode engine.
// ----------------------------------------------------------------------------
// Each input word either supplies one packed code byte (LSB first) or pulls
// one decoded byte; every word gives exactly one result word. A pull served
// from the output stack reads the stack memory. A pull that must decode
// consumes codes until one gives bytes and, for a dictionary code, walks its
// string with one prefix/suffix memory read per chain step.
// Registers: 0x0 first_code_width, 0x4 root_count; write only while idle.
`default_nettype none
module gif_lzw_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        mode,
	input  wire logic [7:0]  coded_byte,
	input  wire logic        final_byte,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [2:0]       status,
	output logic [7:0]       out_byte
);
	import gld_pkg::*;

	logic [CW_W-1:0]   fcw_q;
	logic [ROOT_W-1:0] roots_q;
	logic [CW_W-1:0]   eff_width;
	logic [ROOT_W-1:0] eff_roots;
	logic              q_valid;
	item_t             q_item;
	logic              q_pop;

	assign pready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcw_q   <= CW_W'(MIN_WIDTH);
			roots_q <= ROOT_W'(MIN_ROOTS);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_FIRST_WIDTH: fcw_q   <= pwdata[CW_W-1:0];
				REG_ROOT_COUNT:  roots_q <= pwdata[ROOT_W-1:0];
				default:         fcw_q   <= fcw_q;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[2])
			REG_FIRST_WIDTH: prdata = 32'(fcw_q);
			REG_ROOT_COUNT:  prdata = 32'(roots_q);
			default:         prdata = 32'd0;
		endcase
	end

	// saturated working values
	always_comb begin
		if (fcw_q < CW_W'(MIN_WIDTH))      eff_width = CW_W'(MIN_WIDTH);
		else if (fcw_q > CW_W'(MAX_WIDTH)) eff_width = CW_W'(MAX_WIDTH);
		else                               eff_width = fcw_q;
		if (roots_q < ROOT_W'(MIN_ROOTS))      eff_roots = ROOT_W'(MIN_ROOTS);
		else if (roots_q > ROOT_W'(MAX_ROOTS)) eff_roots = ROOT_W'(MAX_ROOTS);
		else                                   eff_roots = roots_q;
	end

	gld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mode       (mode),
		.coded_byte (coded_byte),
		.final_byte (final_byte),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	gld_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.eff_width    (eff_width),
		.eff_roots    (eff_roots),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.out_byte     (out_byte)
	);

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the GIF-style LZW decoder
// Drives a short fixed table of words, then random but well-formed code
// streams over several register settings, and checks every result word against
// the table's expectation or a cycle-free decoder predictor kept in this module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import gld_pkg::*;

	localparam bit MODE_PUSH = 1'b0;
	localparam bit MODE_PULL = 1'b1;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SEG_CODES = 20;

	typedef enum {PH_WAIT_CLR, PH_FIRST, PH_RUN, PH_DONE, PH_ERR} dec_phase_t;
	typedef enum {OC_NONE, OC_BYTES, OC_END, OC_BAD} code_outcome_t;

	typedef struct {
		logic [2:0] st;
		logic [7:0] ob;
	} result_t;

	typedef struct {
		bit         m;
		bit [7:0]   b;
		bit         f;
		logic [2:0] st;
		logic [7:0] ob;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_stall;
	logic        mode;
	logic [7:0]  coded_byte;
	logic        final_byte;
	logic        result_valid;
	logic        result_stall;
	logic [2:0]  status;
	logic [7:0]  out_byte;

	gif_lzw_decoder_top dut (.*);

	// decoder predictor state
	logic [3:0]   p_fw;
	logic [8:0]   p_rc;
	logic [11:0]  pfx_tab [TABLE_DEPTH];
	logic [7:0]   sfx_tab [TABLE_DEPTH];
	logic [7:0]   fst_tab [TABLE_DEPTH];
	logic [7:0]   out_stk [TABLE_DEPTH];
	int unsigned  sdep, nfree, cw, prev_code, bbuf, bcnt;
	dec_phase_t   ph;
	bit           ended;

	result_t      pending_q [$];
	int           errors;
	int           words_in;
	int           results_seen;
	int           cycles;
	logic [2:0]   last_status;

	// typed expectation carried with the word on the bus
	bit           cur_typed;
	logic [2:0]   cur_st;
	logic [7:0]   cur_ob;

	// code stream generator state
	int unsigned  g_w, g_nf, g_roots, g_acc, g_nacc;
	bit           g_first;

	function automatic int unsigned eff_width(logic [3:0] v);
		if (v < MIN_WIDTH) return MIN_WIDTH;
		if (v > MAX_WIDTH) return MAX_WIDTH;
		return v;
	endfunction

	function automatic int unsigned eff_roots(logic [8:0] v);
		if (v < MIN_ROOTS) return MIN_ROOTS;
		if (v > MAX_ROOTS) return MAX_ROOTS;
		return v;
	endfunction

	function void stack_push(int unsigned b);
		if (sdep < TABLE_DEPTH) begin
			out_stk[sdep] = b[7:0];
			sdep++;
		end
	endfunction

	function int unsigned first_byte_of(int unsigned c);
		if (c < eff_roots(p_rc)) return c;
		if (c < TABLE_DEPTH) return fst_tab[c];
		return 0;
	endfunction

	// walk the prefix chain, pushing suffixes, then the root
	function void expand_string(int unsigned c);
		int unsigned guard;
		guard = 0;
		while (c >= eff_roots(p_rc) && c < TABLE_DEPTH && guard < TABLE_DEPTH) begin
			stack_push(sfx_tab[c]);
			c = pfx_tab[c];
			guard++;
		end
		stack_push(c);
	endfunction

	function void add_string(int unsigned b);
		if (nfree >= TABLE_DEPTH) return;
		pfx_tab[nfree] = prev_code[11:0];
		sfx_tab[nfree] = b[7:0];
		fst_tab[nfree] = first_byte_of(prev_code);
		if (nfree >= (32'd1 << cw) - 1 && cw < MAX_WIDTH) cw++;
		nfree++;
	endfunction

	function void restart_table();
		cw = eff_width(p_fw);
		nfree = eff_roots(p_rc) + 2;
		ph = PH_FIRST;
	endfunction

	function code_outcome_t interpret_code(int unsigned c);
		int unsigned roots;
		roots = eff_roots(p_rc);
		if (ph == PH_WAIT_CLR) begin
			if (c == roots) begin
				restart_table();
				return OC_NONE;
			end
			return OC_BAD;
		end
		if (c == roots) begin
			restart_table();
			return OC_NONE;
		end
		if (c == roots + 1) return OC_END;
		if (ph == PH_FIRST) begin
			if (c < roots) begin
				stack_push(c);
				prev_code = c;
				ph = PH_RUN;
				return OC_BYTES;
			end
			return OC_BAD;
		end
		if (c < nfree) begin
			expand_string(c);
			add_string(first_byte_of(c));
			prev_code = c;
			return OC_BYTES;
		end
		// code not yet in the table: previous string plus its own first byte
		if (c == nfree && nfree < TABLE_DEPTH) begin
			stack_push(first_byte_of(prev_code));
			expand_string(prev_code);
			add_string(first_byte_of(prev_code));
			prev_code = c;
			return OC_BYTES;
		end
		return OC_BAD;
	endfunction

	function result_t decode_word(bit m, bit [7:0] b, bit f);
		result_t       r;
		int unsigned   w, c;
		code_outcome_t oc;
		r.st = STAT_DATA;
		r.ob = 8'd0;
		if (m == MODE_PUSH) begin
			if (ph == PH_DONE || ph == PH_ERR || ended || bcnt > ACCEPT_MAX_BITS) begin
				r.st = STAT_REJECTED;
			end else begin
				bbuf = (bbuf | (32'(b) << bcnt)) & 32'hFFFFF;
				bcnt += 8;
				ended = f;
				r.st = STAT_ACCEPTED;
			end
		end else if (sdep > 0) begin
			sdep--;
			r.ob = out_stk[sdep];
		end else if (ph == PH_DONE) begin
			r.st = STAT_FINISHED;
		end else if (ph == PH_ERR) begin
			r.st = STAT_ERROR;
		end else begin
			// decode codes until one gives bytes or decoding stops
			while (1) begin
				w = (ph == PH_WAIT_CLR) ? eff_width(p_fw) : cw;
				if (bcnt < w) begin
					if (ended) begin
						ph = PH_ERR;
						r.st = STAT_ERROR;
					end else begin
						r.st = STAT_NEED_IN;
					end
					break;
				end
				c = bbuf & ((32'd1 << w) - 1);
				bbuf >>= w;
				bcnt -= w;
				oc = interpret_code(c);
				if (oc == OC_NONE) continue;
				if (oc == OC_BYTES) begin
					if (sdep > 0) begin
						sdep--;
						r.ob = out_stk[sdep];
					end
					r.st = STAT_DATA;
				end else if (oc == OC_END) begin
					ph = PH_DONE;
					r.st = STAT_FINISHED;
				end else begin
					ph = PH_ERR;
					r.st = STAT_ERROR;
				end
				break;
			end
		end
		if (r.st != STAT_DATA) r.ob = 8'd0;
		return r;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("gif_lzw_decoder_top test failed");
			$finish;
		end
	end

	// receiver stall: bursts of random length, with quiet stretches
	int stall_hold;
	always @(negedge clk) begin
		int r;
		if (stall_hold > 0) begin
			stall_hold--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				result_stall <= 1'b0;
				stall_hold = $urandom_range(0, 8);
			end else if (r < 60) begin
				result_stall <= 1'b0;
				stall_hold = 60;
			end else if (r < 95) begin
				result_stall <= 1'b1;
				stall_hold = $urandom_range(0, 2);
			end else begin
				result_stall <= 1'b1;
				stall_hold = $urandom_range(5, 40);
			end
		end
	end

	// predict on accepted words, check accepted results
	always @(posedge clk) begin
		result_t e;
		result_t got;
		if (arst_n && item_valid && !item_stall) begin
			e = decode_word(mode, coded_byte, final_byte);
			if (cur_typed) begin
				e.st = cur_st;
				e.ob = cur_ob;
			end
			pending_q.push_back(e);
			words_in++;
		end
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			last_status = status;
			if (pending_q.size() == 0) begin
				$error("result word with nothing expected: status %0d byte %0d",
					status, out_byte);
				errors++;
			end else begin
				got = pending_q.pop_front();
				if (status !== got.st) begin
					$error("status: expected %0d, got %0d", got.st, status);
					errors++;
				end
				if (out_byte !== got.ob) begin
					$error("out_byte: expected %0d, got %0d", got.ob, out_byte);
					errors++;
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	task automatic send_word(bit m, bit [7:0] b, bit f, bit typed,
			logic [2:0] st, logic [7:0] ob);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		mode <= m;
		coded_byte <= b;
		final_byte <= f;
		cur_typed <= typed;
		cur_st <= st;
		cur_ob <= ob;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic send_pull();
		send_word(MODE_PULL, 8'($urandom), 1'($urandom), 1'b0, STAT_DATA, 8'd0);
	endtask

	// drop valid and wait until every expected word has come
	task automatic wait_quiet();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] d);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == {REG_FIRST_WIDTH, 2'b00}) p_fw = d[3:0];
		else p_rc = d[8:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// push one code byte; a rejected byte is retried after a pull
	task automatic push_coded(bit [7:0] b, bit f);
		int tries;
		for (tries = 0; tries < 4; tries++) begin
			send_word(MODE_PUSH, b, f, 1'b0, STAT_DATA, 8'd0);
			wait_quiet();
			if (last_status != STAT_REJECTED) break;
			send_pull();
			wait_quiet();
			if (last_status == STAT_FINISHED || last_status == STAT_ERROR) break;
		end
	endtask

	// pack one code LSB first; full bytes go out with zero to three pulls after each
	task automatic emit_code(int unsigned c);
		int n, k;
		g_acc |= c << g_nacc;
		g_nacc += g_w;
		while (g_nacc >= 8) begin
			push_coded(g_acc[7:0], 1'b0);
			g_acc >>= 8;
			g_nacc -= 8;
			n = $urandom_range(0, 3);
			for (k = 0; k < n; k++) send_pull();
		end
	endtask

	// one run code: a root while first, else a table code, tracking additions and width growth
	task automatic emit_run_code();
		int unsigned c, hi, r;
		if (g_first) begin
			c = $urandom_range(0, g_roots - 1);
			emit_code(c);
			g_first = 0;
			return;
		end
		hi = (g_nf < TABLE_DEPTH) ? g_nf : TABLE_DEPTH - 1;
		r = $urandom_range(0, 99);
		if (r < 15 && g_nf < TABLE_DEPTH) c = g_nf;
		else if (r < 40 || hi < g_roots + 2) c = $urandom_range(0, g_roots - 1);
		else c = $urandom_range(g_roots + 2, hi);
		emit_code(c);
		if (g_nf < TABLE_DEPTH) begin
			if (g_nf >= (32'd1 << g_w) - 1 && g_w < MAX_WIDTH) g_w++;
			g_nf++;
		end
	endtask

	// pull until the decoder has no complete code left
	task automatic drain_codes();
		do begin
			send_pull();
			wait_quiet();
		end while (last_status != STAT_NEED_IN && last_status != STAT_FINISHED
			&& last_status != STAT_ERROR);
	endtask

	// fixed words from reset settings: width 3, four roots.
	// codes clear,1,2,6 at 3 bits, then 8 at 4 bits: decodes 1 2 1 2 1 2 1
	dir_row_t dir_rows [13] = '{
		'{MODE_PULL, 8'hFF, 1'b1, STAT_NEED_IN,  8'd0},
		'{MODE_PUSH, 8'h8C, 1'b0, STAT_ACCEPTED, 8'd0},
		'{MODE_PULL, 8'h00, 1'b0, STAT_DATA,     8'd1},
		'{MODE_PULL, 8'h00, 1'b1, STAT_NEED_IN,  8'd0},
		'{MODE_PUSH, 8'h8C, 1'b0, STAT_ACCEPTED, 8'd0},
		'{MODE_PULL, 8'h55, 1'b0, STAT_DATA,     8'd2},
		'{MODE_PULL, 8'hAA, 1'b0, STAT_DATA,     8'd1},
		'{MODE_PULL, 8'h00, 1'b0, STAT_DATA,     8'd2},
		'{MODE_PULL, 8'hFF, 1'b0, STAT_DATA,     8'd1},
		'{MODE_PULL, 8'h00, 1'b0, STAT_DATA,     8'd2},
		'{MODE_PULL, 8'h00, 1'b0, STAT_DATA,     8'd1},
		'{MODE_PULL, 8'h00, 1'b0, STAT_NEED_IN,  8'd0},
		'{MODE_PULL, 8'h00, 1'b0, STAT_NEED_IN,  8'd0}
	};

	// register settings per segment; out-of-range values check saturation
	logic [3:0] seg_fw [8] = '{4'd4, 4'd7, 4'd8, 4'd12, 4'd15, 4'd0, 4'd6, 4'd2};
	logic [8:0] seg_rc [8] = '{9'd13, 9'd100, 9'd200, 9'd511, 9'd300, 9'd0, 9'd40, 9'd3};

	initial begin
		int i, s, k;
		int unsigned new_r;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 3'd0;
		pwdata = 32'd0;
		item_valid = 1'b0;
		mode = MODE_PULL;
		coded_byte = 8'd0;
		final_byte = 1'b0;
		result_stall = 1'b0;
		cur_typed = 1'b0;
		cur_st = STAT_DATA;
		cur_ob = 8'd0;
		stall_hold = 0;
		errors = 0;
		words_in = 0;
		results_seen = 0;
		cycles = 0;
		last_status = STAT_DATA;
		p_fw = 4'd3;
		p_rc = 9'd4;
		sdep = 0;
		nfree = 0;
		cw = 3;
		prev_code = 0;
		bbuf = 0;
		bcnt = 0;
		ph = PH_WAIT_CLR;
		ended = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (i = 0; i < 13; i++)
			send_word(dir_rows[i].m, dir_rows[i].b, dir_rows[i].f, 1'b1,
				dir_rows[i].st, dir_rows[i].ob);
		wait_quiet();

		// generator picks up where the table left the decoder
		g_w = 4;
		g_nf = 9;
		g_roots = 4;
		g_first = 0;
		g_acc = 0;
		g_nacc = 0;

		// random streams: each segment sets new registers and starts with a clear
		for (s = 0; s < 8; s++) begin
			new_r = eff_roots(seg_rc[s]);
			while ((32'd1 << g_w) <= new_r) emit_run_code();
			drain_codes();
			repeat (40) @(negedge clk);
			reg_write({REG_FIRST_WIDTH, 2'b00}, 32'(seg_fw[s]));
			reg_write({REG_ROOT_COUNT, 2'b00}, 32'(seg_rc[s]));
			emit_code(new_r);
			g_roots = new_r;
			g_w = eff_width(seg_fw[s]);
			g_nf = new_r + 2;
			g_first = 1;
			for (k = 0; k < SEG_CODES; k++) begin
				emit_run_code();
				if ($urandom_range(0, 9) == 0) begin
					emit_code(g_roots);
					g_w = eff_width(seg_fw[s]);
					g_nf = g_roots + 2;
					g_first = 1;
				end
			end
		end

		// end code, last byte flagged, pulls until finished, then one more push and pull
		emit_code(g_roots + 1);
		if (g_nacc > 0) push_coded(g_acc[7:0], 1'b1);
		else push_coded(8'($urandom), 1'b1);
		drain_codes();
		send_word(MODE_PUSH, 8'hFF, 1'b1, 1'b0, STAT_DATA, 8'd0);
		send_pull();
		wait_quiet();
		repeat (200) @(negedge clk);

		$display("covered %0d words in %0d register segments, %0d result words checked",
			words_in, 8, results_seen);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("gif_lzw_decoder_top test passed");
		end else begin
			$display("gif_lzw_decoder_top test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
